>>> rtl/b32se_pkg.sv
// package for the base32 stream encoder
// holds the alphabet select codes, the four character tables and the lookup
// function; no dependencies
package b32se_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned GroupW  = 5;
	localparam int unsigned SelW    = 2;
	localparam int unsigned MaxChars = 3;

	localparam logic [GroupW-1:0] GROUP_MASK = 5'h1F;

	typedef enum logic [SelW-1:0] {
		ALPHA_RFC4648   = 2'd0,
		ALPHA_HEX       = 2'd1,
		ALPHA_ZBASE32   = 2'd2,
		ALPHA_CROCKFORD = 2'd3
	} alpha_sel_t;

	typedef logic [ByteW-1:0] char_t;

	// first character sits in the top byte of each string
	localparam logic [32*ByteW-1:0] RFC4648_CHARS   = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
	localparam logic [32*ByteW-1:0] HEX_CHARS       = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
	localparam logic [32*ByteW-1:0] ZBASE32_CHARS   = "ybndrfg8ejkmcpqxot1uwisza345h769";
	localparam logic [32*ByteW-1:0] CROCKFORD_CHARS = "0123456789ABCDEFGHJKMNPQRSTVWXYZ";

	function automatic char_t char_lookup(alpha_sel_t sel, logic [GroupW-1:0] group);
		logic [GroupW-1:0] pos;
		char_t ch;
		pos = ~(group & GROUP_MASK);
		case (sel)
			ALPHA_RFC4648:   ch = RFC4648_CHARS[ByteW*pos +: ByteW];
			ALPHA_HEX:       ch = HEX_CHARS[ByteW*pos +: ByteW];
			ALPHA_ZBASE32:   ch = ZBASE32_CHARS[ByteW*pos +: ByteW];
			ALPHA_CROCKFORD: ch = CROCKFORD_CHARS[ByteW*pos +: ByteW];
			default:         ch = RFC4648_CHARS[ByteW*pos +: ByteW];
		endcase
		return ch;
	endfunction

endpackage

>>> rtl/base32_stream_encoder_top.sv
// base32 stream encoder, unpadded, four selectable alphabets
// depends on b32se_pkg for the tables and the lookup function
//
// usage:
//  input channel (in_valid / in_stall) carries one byte of a message per item,
//  data_byte msb first, byte_last on the final byte of the message.
//  output channel (out_valid / out_stall) carries one character per item,
//  char_last on the final character of the message.
//  cfg_write loads alphabet_select from cfg_data[1:0]; write only while idle.
// timing:
//  a byte is registered, then encoded in one pass into a character buffer of
//  up to three entries; the first character is offered once the buffer has
//  been loaded from the input register.
//  each byte gives one or two characters; a last byte with bits over gives
//  one more, up to three. the buffer drains one character a cycle while
//  out_stall is low, and the next byte is taken in the cycle its
//  predecessor's last character leaves.
// reset:
//  clears both stages, the leftover bits and count, and selects rfc 4648.
// stall:
//  a stalled character holds; once the buffer and input register are both
//  full, in_stall rises until the buffer's last character is taken.
module base32_stream_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       byte_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code_char,
	output logic       char_last
);

	b32se_pkg::alpha_sel_t alpha_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [3:0] bits_q;
	logic [2:0] count_q;

	logic             valid_s2;
	b32se_pkg::char_t chars_s2 [b32se_pkg::MaxChars];
	logic [1:0]       nchar_s2;
	logic [1:0]       idx_s2;
	logic             last_s2;

	logic        take_out, final_take, buf_free, advance, in_accept;
	logic [2:0]  cnt;
	logic [11:0] acc, tail, mask;
	logic [3:0]  total, rem;
	logic [4:0]  g0, g1, gfin;
	logic        two_groups, has_tail;
	logic [1:0]  nchar;

	assign take_out   = valid_s2 && !out_stall;
	assign final_take = take_out && (idx_s2 == nchar_s2 - 2'd1);
	assign buf_free   = !valid_s2 || final_take;
	assign advance    = valid_s1 && buf_free;
	assign in_stall   = valid_s1 && !buf_free;
	assign in_accept  = in_valid && !in_stall;

	assign out_valid = valid_s2;
	assign code_char = chars_s2[idx_s2];
	assign char_last = last_s2 && (idx_s2 == nchar_s2 - 2'd1);

	// encode the registered byte against the leftover bits
	always_comb begin
		cnt        = (count_q > 3'd4) ? 3'd4 : count_q;
		acc        = {4'(bits_q & ((4'd1 << cnt) - 4'd1)), byte_s1};
		total      = 4'(cnt) + 4'd8;
		two_groups = (total >= 4'd10);
		g0         = 5'(acc >> (total - 4'd5));
		g1         = 5'(acc >> (total - 4'd10));
		rem        = two_groups ? (total - 4'd10) : (total - 4'd5);
		mask       = (12'd1 << rem) - 12'd1;
		tail       = acc & mask;
		gfin       = 5'(tail << (4'd5 - rem));
		has_tail   = last_s1 && (rem != 4'd0);
		nchar      = (two_groups ? 2'd2 : 2'd1) + (has_tail ? 2'd1 : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= b32se_pkg::ALPHA_RFC4648;
		end else if (cfg_write) begin
			alpha_q <= b32se_pkg::alpha_sel_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= data_byte;
			last_s1 <= byte_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= 4'd0;
			count_q <= 3'd0;
		end else if (advance) begin
			if (last_s1) begin
				bits_q  <= 4'd0;
				count_q <= 3'd0;
			end else begin
				bits_q  <= tail[3:0];
				count_q <= rem[2:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			idx_s2   <= 2'd0;
		end else if (final_take) begin
			valid_s2 <= 1'b0;
			idx_s2   <= 2'd0;
		end else if (take_out) begin
			idx_s2 <= idx_s2 + 2'd1;
		end
	end

	// tail character lands after however many full groups there were
	always_ff @(posedge clk) begin
		if (advance) begin
			chars_s2[0] <= b32se_pkg::char_lookup(alpha_q, g0);
			chars_s2[1] <= two_groups ? b32se_pkg::char_lookup(alpha_q, g1)
			                          : b32se_pkg::char_lookup(alpha_q, gfin);
			chars_s2[2] <= b32se_pkg::char_lookup(alpha_q, gfin);
			nchar_s2    <= nchar;
			last_s2     <= last_s1;
		end
	end

endmodule
